>>> src/rgb565_to_yuy2_decimator_macros.svh
// assertion macros for the rgb565 to yuy2 decimator checker
`ifndef RGB565_TO_YUY2_DECIMATOR_MACROS_SVH
`define RGB565_TO_YUY2_DECIMATOR_MACROS_SVH

// consequent checked in the same cycle
`define R2Y_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define R2Y_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// state seen on the cycle after a reset cycle
`define R2Y_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

>>> src/r2y_pkg.sv
// shared types, constants and colour functions of the rgb565 to yuy2 decimator
package r2y_pkg;

   localparam int R2Y_MAX_LINE    = 4096;
   localparam int R2Y_QUEUE_DEPTH = 4;

   localparam int R2Y_CSR_W      = 13;
   localparam int R2Y_CSR_IDX_W  = 3;
   localparam int R2Y_PICK_W     = 24;
   localparam int R2Y_ROW_W      = 12;
   localparam int R2Y_OUT_CNT_W  = 13;

   localparam logic [R2Y_ROW_W-1:0] R2Y_ROW_LAST = '1;

   localparam logic [R2Y_CSR_W-1:0] R2Y_SRC_WIDTH_RST  = 13'd800;
   localparam logic [R2Y_CSR_W-1:0] R2Y_X_STEP_RST     = 13'd1;
   localparam logic [R2Y_CSR_W-1:0] R2Y_Y_STEP_RST     = 13'd1;
   localparam logic [R2Y_CSR_W-1:0] R2Y_OUT_WIDTH_RST  = 13'd800;
   localparam logic [R2Y_CSR_W-1:0] R2Y_OUT_HEIGHT_RST = 13'd640;

   localparam logic [7:0] R2Y_Y_COEF_R = 8'd77;
   localparam logic [7:0] R2Y_Y_COEF_G = 8'd150;
   localparam logic [7:0] R2Y_Y_COEF_B = 8'd29;
   localparam logic signed [8:0] R2Y_CB_COEF = 9'sd144;
   localparam logic signed [8:0] R2Y_CR_COEF = 9'sd183;
   localparam logic signed [10:0] R2Y_CHROMA_OFS = 11'sd128;
   localparam logic signed [10:0] R2Y_PIX_MAX    = 11'sd255;

   typedef enum logic [R2Y_CSR_IDX_W-1:0] {
      R2Y_REG_SRC_WIDTH  = 3'd0,
      R2Y_REG_X_STEP     = 3'd1,
      R2Y_REG_Y_STEP     = 3'd2,
      R2Y_REG_OUT_WIDTH  = 3'd3,
      R2Y_REG_OUT_HEIGHT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic        start_of_frame;
   } req_type;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_u;
      logic [7:0] luma_second;
      logic [7:0] chroma_v;
      logic       end_of_line;
      logic       end_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pixel_first;
      logic [15:0] pixel_second;
      logic        end_of_line;
      logic        end_of_frame;
   } pair_type;

   typedef struct packed {
      logic     valid;
      pair_type pair;
   } pair_push_type;

   function automatic logic [7:0] red8(input logic [15:0] p);
      return {p[15:11], 3'b000};
   endfunction

   function automatic logic [7:0] green8(input logic [15:0] p);
      return {p[10:5], 2'b00};
   endfunction

   function automatic logic [7:0] blue8(input logic [15:0] p);
      return {p[4:0], 3'b000};
   endfunction

   // weights sum to 256, so the sum never exceeds 16 bits
   function automatic logic [7:0] luma8(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
      logic [15:0] sum;
      sum = 16'(R2Y_Y_COEF_R) * 16'(r) + 16'(R2Y_Y_COEF_G) * 16'(g)
          + 16'(R2Y_Y_COEF_B) * 16'(b);
      return sum[15:8];
   endfunction

   function automatic logic [7:0] clamp8(input logic signed [10:0] v);
      logic [7:0] res;
      if (v < 11'sd0) begin
         res = 8'd0;
      end else if (v > R2Y_PIX_MAX) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

endpackage

>>> src/r2y_front.sv
// front end: configuration registers, raster counters and pixel pairing
module r2y_front import r2y_pkg::*; #(
   parameter int MAX_LINE = R2Y_MAX_LINE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   input  logic                     csr_we,
   input  logic [R2Y_CSR_IDX_W-1:0] csr_index,
   input  logic [R2Y_CSR_W-1:0]     csr_wdata,
   input  logic                     queue_full,
   output pair_push_type            push
);

   localparam int CW   = $clog2(MAX_LINE);
   localparam int CMPW = (CW + 1 > R2Y_CSR_W) ? CW + 1 : R2Y_CSR_W;

   logic [R2Y_CSR_W-1:0] src_width_ff, x_step_ff, y_step_ff, out_width_ff, out_height_ff;

   logic [CW-1:0]            col_ff, col_in;
   logic [R2Y_ROW_W-1:0]     row_ff, row_in;
   logic [R2Y_PICK_W-1:0]    npc_ff, npc_in, npr_ff, npr_in;
   logic [R2Y_OUT_CNT_W-1:0] ocol_ff, ocol_in, orow_ff, orow_in;
   logic                     done_ff, done_in;
   logic [15:0]              held_ff, held_in;

   logic                     accept;
   logic [CW-1:0]            col;
   logic [R2Y_ROW_W-1:0]     row;
   logic [R2Y_PICK_W-1:0]    npc, npr;
   logic [R2Y_OUT_CNT_W-1:0] ocol, orow, ow, orow_nx;
   logic                     done, row_sel, pick, line_end, eol;
   logic [CMPW-1:0]          col_nx;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= R2Y_SRC_WIDTH_RST;
         x_step_ff     <= R2Y_X_STEP_RST;
         y_step_ff     <= R2Y_Y_STEP_RST;
         out_width_ff  <= R2Y_OUT_WIDTH_RST;
         out_height_ff <= R2Y_OUT_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            R2Y_REG_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            R2Y_REG_X_STEP:     x_step_ff     <= csr_wdata;
            R2Y_REG_Y_STEP:     y_step_ff     <= csr_wdata;
            R2Y_REG_OUT_WIDTH:  out_width_ff  <= csr_wdata;
            R2Y_REG_OUT_HEIGHT: out_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      col  = req_data.start_of_frame ? '0 : col_ff;
      row  = req_data.start_of_frame ? '0 : row_ff;
      npc  = req_data.start_of_frame ? '0 : npc_ff;
      npr  = req_data.start_of_frame ? '0 : npr_ff;
      ocol = req_data.start_of_frame ? '0 : ocol_ff;
      orow = req_data.start_of_frame ? '0 : orow_ff;
      done = req_data.start_of_frame ? 1'b0 : done_ff;

      ow      = {out_width_ff[R2Y_CSR_W-1:1], 1'b0};
      row_sel = !done && (npr == R2Y_PICK_W'(row)) && (orow < out_height_ff);
      pick    = row_sel && (npc == R2Y_PICK_W'(col)) && (ocol < ow);
      eol     = (14'(ocol) + 14'd1) == 14'(ow);
      col_nx  = CMPW'(col) + CMPW'(1);
      line_end = (col_nx >= CMPW'(src_width_ff)) || (col_nx >= CMPW'(MAX_LINE));
      orow_nx = orow + R2Y_OUT_CNT_W'(1);

      push.valid             = accept && pick && ocol[0];
      push.pair.pixel_first  = held_ff;
      push.pair.pixel_second = req_data.pixel;
      push.pair.end_of_line  = eol;
      push.pair.end_of_frame = eol && ((14'(orow) + 14'd1) == 14'(out_height_ff));

      held_in = held_ff;
      col_in  = col;
      row_in  = row;
      npc_in  = npc;
      npr_in  = npr;
      ocol_in = ocol;
      orow_in = orow;
      done_in = done;

      if (pick) begin
         if (!ocol[0]) begin
            held_in = req_data.pixel;
         end
         ocol_in = ocol + R2Y_OUT_CNT_W'(1);
         npc_in  = npc + R2Y_PICK_W'(x_step_ff);
      end

      if (line_end) begin
         col_in = '0;
         if (row < R2Y_ROW_LAST) begin
            row_in = row + R2Y_ROW_W'(1);
         end
         if (row_sel) begin
            orow_in = orow_nx;
            npr_in  = npr + R2Y_PICK_W'(y_step_ff);
            if (orow_nx >= out_height_ff) begin
               done_in = 1'b1;
            end
         end
         ocol_in = '0;
         npc_in  = '0;
      end else begin
         col_in = col + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         npc_ff  <= '0;
         npr_ff  <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         done_ff <= 1'b0;
      end else if (accept) begin
         held_ff <= held_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         npc_ff  <= npc_in;
         npr_ff  <= npr_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
         done_ff <= done_in;
      end
   end

endmodule

>>> src/r2y_queue.sv
// short pair queue between front end and colour conversion
module r2y_queue import r2y_pkg::*; #(
   parameter int DEPTH = R2Y_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  pair_push_type push,
   output logic          full,
   output logic          head_valid,
   output pair_type      head,
   input  logic          pop
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   pair_type        store_ff [DEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [NW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == NW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = store_ff[rptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wptr_ff] <= push.pair;
      end
   end

endmodule

>>> src/r2y_back.sv
// back end: two-stage bt.601 conversion of a pixel pair with output register
module r2y_back import r2y_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pair_type in_pair,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic       s1_valid_ff;
   logic [7:0] y0_ff, y1_ff, ya_ff, ra_ff, ba_ff;
   logic       eol_ff, eof_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   logic       out_ready, s1_ready, s1_load;
   logic [8:0] r_sum, g_sum, b_sum;
   logic [7:0] ra_in, ga_in, ba_in;
   logic signed [8:0]  du, dv;
   logic signed [17:0] tu, tv;
   logic signed [10:0] u_pre, v_pre;
   rsp_type    rsp_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign in_ready  = s1_ready;
   assign s1_load   = in_valid && s1_ready;

   always_comb begin
      r_sum = 9'(red8(in_pair.pixel_first))   + 9'(red8(in_pair.pixel_second));
      g_sum = 9'(green8(in_pair.pixel_first)) + 9'(green8(in_pair.pixel_second));
      b_sum = 9'(blue8(in_pair.pixel_first))  + 9'(blue8(in_pair.pixel_second));
      ra_in = r_sum[8:1];
      ga_in = g_sum[8:1];
      ba_in = b_sum[8:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         y0_ff  <= luma8(red8(in_pair.pixel_first), green8(in_pair.pixel_first),
                         blue8(in_pair.pixel_first));
         y1_ff  <= luma8(red8(in_pair.pixel_second), green8(in_pair.pixel_second),
                         blue8(in_pair.pixel_second));
         ya_ff  <= luma8(ra_in, ga_in, ba_in);
         ra_ff  <= ra_in;
         ba_ff  <= ba_in;
         eol_ff <= in_pair.end_of_line;
         eof_ff <= in_pair.end_of_frame;
      end
   end

   // arithmetic shift gives the floor of the scaled difference
   always_comb begin
      du    = $signed({1'b0, ba_ff}) - $signed({1'b0, ya_ff});
      dv    = $signed({1'b0, ra_ff}) - $signed({1'b0, ya_ff});
      tu    = du * R2Y_CB_COEF;
      tv    = dv * R2Y_CR_COEF;
      u_pre = $signed(tu[17:8]) + R2Y_CHROMA_OFS;
      v_pre = $signed(tv[17:8]) + R2Y_CHROMA_OFS;
      rsp_in.luma_first   = y0_ff;
      rsp_in.chroma_u     = clamp8(u_pre);
      rsp_in.luma_second  = y1_ff;
      rsp_in.chroma_v     = clamp8(v_pre);
      rsp_in.end_of_line  = eol_ff;
      rsp_in.end_of_frame = eof_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/rgb565_to_yuy2_decimator.sv
// top level of the rgb565 to yuy2 nearest-neighbour decimator
//
//   channel  ports             moves per transfer
//   req      req_valid/stall   one rgb565 source pixel with start of frame mark
//   rsp      rsp_valid/stall   one y0 u y1 v group with end of line/frame marks
//   csr      csr_we            one 13-bit register write, no handshake back
//
// one source pixel per cycle while req_stall is low; rsp_valid rises after the edge that takes
// a pair's second pixel, through the queue entry, the luma stage and the output register
// req_stall rises only when the pair queue holds QUEUE_DEPTH pairs
// synchronous reset clears counters, queue and pipeline valids and sets the csr registers to their defaults
module rgb565_to_yuy2_decimator import r2y_pkg::*; #(
   parameter int MAX_LINE    = R2Y_MAX_LINE,
   parameter int QUEUE_DEPTH = R2Y_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [R2Y_CSR_IDX_W-1:0] csr_index,
   input  logic [R2Y_CSR_W-1:0]     csr_wdata
);

   pair_push_type push;
   logic          queue_full, head_valid, back_ready;
   pair_type      head;

   r2y_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push)
   );

   r2y_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (back_ready)
   );

   r2y_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (head_valid),
      .in_ready  (back_ready),
      .in_pair   (head),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/r2y_checker.sv
// port checker for the rgb565 to yuy2 decimator and its bind
`include "rgb565_to_yuy2_decimator_macros.svh"

module r2y_checker import r2y_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `R2Y_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `R2Y_ASSERT_SAME(a_eof_on_eol, clock, reset, rsp_valid && rsp_data.end_of_frame, rsp_data.end_of_line, "end of frame without end of line")
   `R2Y_ASSERT_AFTER_RESET(a_rsp_idle_after_reset, clock, reset, !rsp_valid, "result valid after reset")
   `R2Y_ASSERT_AFTER_RESET(a_req_open_after_reset, clock, reset, !req_stall, "input stalled after reset")

endmodule

bind rgb565_to_yuy2_decimator r2y_checker u_r2y_checker (.*);
